// File: src/linear_probe_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Shared assertion forms for the checker of the hash table.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define LPHT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht implication check failed");

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define LPHT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht next-cycle check failed");

`endif

// File: src/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Status codes, the stored entry layout, the response record and helpers.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int MAX_SLOTS = 256;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [63:0] hash;
        logic [31:0] name;
        logic [31:0] owner;
        logic [31:0] mtype;
        logic [31:0] stride;
        logic [31:0] extra;
    } entry_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [31:0] found_name_id;
        logic [31:0] found_owner_id;
        logic [31:0] found_type;
        logic [31:0] found_stride;
        logic [32:0] element_count;
        logic [8:0]  entries_used;
        logic [8:0]  capacity_now;
    } rsp_t;

    // Smallest power of two not below n.
    function automatic logic [31:0] next_pow2(input logic [31:0] n);
        logic [31:0] m;
        begin
            m = n - 32'd1;
            m = m | (m >> 1);
            m = m | (m >> 2);
            m = m | (m >> 4);
            m = m | (m >> 8);
            m = m | (m >> 16);
            next_pow2 = (n == 32'd0) ? 32'd1 : (m + 32'd1);
        end
    endfunction

endpackage

// File: src/lpht_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table request channel
// Carries one insert or lookup request with its member record.
// ----------------------------------------------------------------------------
interface lpht_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] key_hash;
    logic [31:0] name_id;
    logic [31:0] owner_id;
    logic [31:0] member_type;
    logic [31:0] stride;
    logic [31:0] extra_elems;

    modport source (output valid, action, key_hash, name_id, owner_id, member_type,
                    stride, extra_elems, input ready);
    modport sink (input valid, action, key_hash, name_id, owner_id, member_type,
                  stride, extra_elems, output ready);
endinterface

// File: src/lpht_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table response channel
// Carries the outcome of one request.
// ----------------------------------------------------------------------------
interface lpht_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [31:0] found_name_id;
    logic [31:0] found_owner_id;
    logic [31:0] found_type;
    logic [31:0] found_stride;
    logic [32:0] element_count;
    logic [8:0]  entries_used;
    logic [8:0]  capacity_now;

    modport source (output valid, status, slot, found_name_id, found_owner_id, found_type,
                    found_stride, element_count, entries_used, capacity_now, input ready);
    modport sink (input valid, status, slot, found_name_id, found_owner_id, found_type,
                  found_stride, element_count, entries_used, capacity_now, output ready);
endinterface

// File: src/lpht_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table configuration channel
// Writes the initial capacity register.
// ----------------------------------------------------------------------------
interface lpht_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] initial_capacity;

    modport source (output valid, initial_capacity, input ready);
    modport sink (input valid, initial_capacity, output ready);
endinterface

// File: src/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing member table with linear probing and growth by rehash.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// req     | in        | action, key hash and member record
// rsp     | out       | status, slot, found record, entries used, capacity
// cfg     | in        | initial capacity
//
// A request runs the bit-serial hash modulo, then for each probed slot a read
// state and a check state on the single memory read port, and then posts.
// Growth clears the new bank, reads and checks each old slot, and for each
// entry moved probes the new bank with a read state and a check state.
// After reset and after every configuration write, a clearing pass over the
// 2**clog2(MAX_SLOTS) slots of bank 0 runs while no request is taken.
// A stalled response waits in its register; the next request is taken meanwhile.
module linear_probe_hash_table (
    input  logic          clk,
    input  logic          rst_n,
    lpht_req_if.sink      req,
    lpht_rsp_if.source    rsp,
    lpht_cfg_if.sink      cfg
);

    localparam int IW = $clog2(lpht_pkg::MAX_SLOTS);
    localparam int CW = IW + 1;
    localparam int DEPTH = 2 ** (IW + 1);
    localparam logic [CW-1:0] RESET_CAP =
        CW'((lpht_pkg::MAX_SLOTS < 16) ? lpht_pkg::MAX_SLOTS : 16);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_GCLR  = 11'b00000001000,
        S_GRD   = 11'b00000010000,
        S_GCHK  = 11'b00000100000,
        S_GPRD  = 11'b00001000000,
        S_GPCHK = 11'b00010000000,
        S_PRD   = 11'b00100000000,
        S_PCHK  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    lpht_pkg::entry_t mem [DEPTH];
    lpht_pkg::entry_t rd_data_reg;
    lpht_pkg::entry_t mov_reg, mov_next;
    lpht_pkg::entry_t wr_data;
    logic [IW:0]      rd_addr, wr_addr;
    logic             wr_en;

    state_t           state_reg, state_next;
    logic [CW-1:0]    cap_reg, cap_next;
    logic [CW-1:0]    newcap_reg, newcap_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             bank_reg, bank_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [5:0]       div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;
    lpht_pkg::rsp_t   out_reg, out_next;
    lpht_pkg::rsp_t   res_reg, res_next;

    logic             action_reg;
    logic [63:0]      key_reg;
    logic [31:0]      name_reg, owner_reg, type_reg, stride_reg, extra_reg;

    logic [CW-1:0]    div_trial;
    logic [CW-1:0]    rem_step;
    logic [31:0]      grow_cap;
    logic [CW-1:0]    new_mask;
    logic [CW-1:0]    cfg_cap;
    logic             src_last, j_last, n_last, adv_src;
    logic             req_take;

    assign req.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign req_take  = req.valid && req.ready;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.slot           = out_reg.slot;
    assign rsp.found_name_id  = out_reg.found_name_id;
    assign rsp.found_owner_id = out_reg.found_owner_id;
    assign rsp.found_type     = out_reg.found_type;
    assign rsp.found_stride   = out_reg.found_stride;
    assign rsp.element_count  = out_reg.element_count;
    assign rsp.entries_used   = out_reg.entries_used;
    assign rsp.capacity_now   = out_reg.capacity_now;

    always_comb
    begin
        div_trial = {rem_reg[CW-2:0], key_reg[~div_cnt_reg]};
        rem_step  = (div_trial >= cap_reg) ? (div_trial - cap_reg) : div_trial;
        grow_cap  = lpht_pkg::next_pow2(32'(cap_reg) + 32'd1);
        new_mask  = newcap_reg - {{(CW-1){1'b0}}, 1'b1};
        src_last  = ({1'b0, idx_reg} == (cap_reg - {{(CW-1){1'b0}}, 1'b1}));
        j_last    = ({1'b0, j_reg} == (cap_reg - {{(CW-1){1'b0}}, 1'b1}));
        n_last    = (n_reg == (cap_reg - {{(CW-1){1'b0}}, 1'b1}));
        if (cfg.initial_capacity == 9'd0)
        begin
            cfg_cap = {{(CW-1){1'b0}}, 1'b1};
        end
        else if (32'(cfg.initial_capacity) > 32'(lpht_pkg::MAX_SLOTS))
        begin
            cfg_cap = CW'(lpht_pkg::MAX_SLOTS);
        end
        else
        begin
            cfg_cap = CW'(cfg.initial_capacity);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        newcap_next    = newcap_reg;
        count_next     = count_reg;
        bank_next      = bank_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        mov_next       = mov_reg;
        rd_addr        = {bank_reg, j_reg};
        wr_en          = 1'b0;
        wr_addr        = {bank_reg, j_reg};
        wr_data        = '0;
        adv_src        = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = {1'b0, idx_reg};
                idx_next = idx_reg + {{(IW-1){1'b0}}, 1'b1};
                if (idx_reg == {IW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_take)
                begin
                    rem_next     = '0;
                    div_cnt_next = '0;
                    res_next     = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next     = rem_step;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'd63)
                begin
                    j_next = rem_step[IW-1:0];
                    n_next = '0;
                    if ((action_reg == lpht_pkg::ACT_INSERT) && (count_reg >= (cap_reg >> 1)))
                    begin
                        if (grow_cap > 32'(lpht_pkg::MAX_SLOTS))
                        begin
                            res_next.status = lpht_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            newcap_next = CW'(grow_cap);
                            idx_next    = '0;
                            state_next  = S_GCLR;
                        end
                    end
                    else
                    begin
                        state_next = S_PRD;
                    end
                end
            end
            S_GCLR:
            begin
                wr_en   = 1'b1;
                wr_addr = {~bank_reg, idx_reg};
                if ({1'b0, idx_reg} == new_mask)
                begin
                    idx_next   = '0;
                    state_next = S_GRD;
                end
                else
                begin
                    idx_next = idx_reg + {{(IW-1){1'b0}}, 1'b1};
                end
            end
            S_GRD:
            begin
                rd_addr    = {bank_reg, idx_reg};
                state_next = S_GCHK;
            end
            S_GCHK:
            begin
                if (rd_data_reg.valid)
                begin
                    mov_next   = rd_data_reg;
                    j_next     = rd_data_reg.hash[IW-1:0] & new_mask[IW-1:0];
                    state_next = S_GPRD;
                end
                else
                begin
                    adv_src = 1'b1;
                end
            end
            S_GPRD:
            begin
                rd_addr    = {~bank_reg, j_reg};
                state_next = S_GPCHK;
            end
            S_GPCHK:
            begin
                if (!rd_data_reg.valid)
                begin
                    wr_en   = 1'b1;
                    wr_addr = {~bank_reg, j_reg};
                    wr_data = mov_reg;
                    adv_src = 1'b1;
                end
                else
                begin
                    j_next     = (j_reg + {{(IW-1){1'b0}}, 1'b1}) & new_mask[IW-1:0];
                    state_next = S_GPRD;
                end
            end
            S_PRD:
            begin
                rd_addr    = {bank_reg, j_reg};
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                state_next = S_DONE;
                if (action_reg == lpht_pkg::ACT_INSERT)
                begin
                    if (!rd_data_reg.valid)
                    begin
                        wr_en           = 1'b1;
                        wr_data         = '{1'b1, key_reg, name_reg, owner_reg, type_reg,
                                            stride_reg, extra_reg};
                        count_next      = count_reg + {{(CW-1){1'b0}}, 1'b1};
                        res_next.status = lpht_pkg::ST_INSERTED;
                        res_next.slot   = 8'(j_reg);
                    end
                    else if ((rd_data_reg.name == name_reg) && (rd_data_reg.owner == owner_reg))
                    begin
                        res_next.status = lpht_pkg::ST_DUPLICATE;
                        res_next.slot   = 8'(j_reg);
                    end
                    else if (n_last)
                    begin
                        res_next.status = lpht_pkg::ST_FULL;
                    end
                    else
                    begin
                        state_next = S_PRD;
                    end
                end
                else
                begin
                    if (!rd_data_reg.valid)
                    begin
                        res_next.status = lpht_pkg::ST_NOT_FOUND;
                    end
                    else if (rd_data_reg.hash == key_reg)
                    begin
                        res_next.status         = lpht_pkg::ST_FOUND;
                        res_next.slot           = 8'(j_reg);
                        res_next.found_name_id  = rd_data_reg.name;
                        res_next.found_owner_id = rd_data_reg.owner;
                        res_next.found_type     = rd_data_reg.mtype;
                        res_next.found_stride   = rd_data_reg.stride;
                        res_next.element_count  = {1'b0, rd_data_reg.extra} + 33'd1;
                    end
                    else if (n_last)
                    begin
                        res_next.status = lpht_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        state_next = S_PRD;
                    end
                end
                if (state_next == S_PRD)
                begin
                    j_next = j_last ? '0 : (j_reg + {{(IW-1){1'b0}}, 1'b1});
                    n_next = n_reg + {{(CW-1){1'b0}}, 1'b1};
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next              = res_reg;
                    out_next.entries_used = 9'(count_reg);
                    out_next.capacity_now = 9'(cap_reg);
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv_src)
        begin
            if (src_last)
            begin
                bank_next  = ~bank_reg;
                cap_next   = newcap_reg;
                j_next     = key_reg[IW-1:0] & new_mask[IW-1:0];
                n_next     = '0;
                state_next = S_PRD;
            end
            else
            begin
                idx_next   = idx_reg + {{(IW-1){1'b0}}, 1'b1};
                state_next = S_GRD;
            end
        end

        if (cfg.valid && cfg.ready)
        begin
            cap_next   = cfg_cap;
            count_next = '0;
            bank_next  = 1'b0;
            idx_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cap_reg       <= RESET_CAP;
            newcap_reg    <= '0;
            count_reg     <= '0;
            bank_reg      <= 1'b0;
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            newcap_reg    <= newcap_next;
            count_reg     <= count_next;
            bank_reg      <= bank_next;
            idx_reg       <= idx_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg   <= j_next;
        n_reg   <= n_next;
        rem_reg <= rem_next;
        out_reg <= out_next;
        res_reg <= res_next;
        mov_reg <= mov_next;
        if (req_take)
        begin
            action_reg <= req.action;
            key_reg    <= req.key_hash;
            name_reg   <= req.name_id;
            owner_reg  <= req.owner_id;
            type_reg   <= req.member_type;
            stride_reg <= req.stride;
            extra_reg  <= req.extra_elems;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: src/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table checker
// Port-level checks on the response channel and request acceptance.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_macros.svh"

module lpht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_status,
    input logic [31:0] rsp_found_name_id,
    input logic [32:0] rsp_element_count,
    input logic [8:0]  rsp_capacity_now
);

    // A held response may not be withdrawn.
    `LPHT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // The table is busy for a while after taking a request.
    `LPHT_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)

    // A found entry always reports a non-zero element count.
    `LPHT_ASSERT_IMP(a_found_count, rsp_valid && (rsp_status == lpht_pkg::ST_FOUND),
                     rsp_element_count != 33'd0)

    // Only a found response carries a record.
    `LPHT_ASSERT_IMP(a_record_zero, rsp_valid && (rsp_status != lpht_pkg::ST_FOUND),
                     (rsp_element_count == 33'd0) && (rsp_found_name_id == 32'd0))

    // Capacity never reads as zero.
    `LPHT_ASSERT_IMP(a_capacity, rsp_valid, rsp_capacity_now != 9'd0)

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_found_name_id (rsp.found_name_id),
    .rsp_element_count (rsp.element_count),
    .rsp_capacity_now  (rsp.capacity_now)
);
